>>> rtl/ifpc_pkg.sv
// Shared constants and types of the IPv4 flow packet counter.
package ifpc_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int COUNT_WIDTH   = 32;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int KEY_W         = 64;
  localparam int REHASH_LIMIT  = 64;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] TABLE_N64 = 64'(TABLE_ENTRIES);
  localparam logic [63:0] HASH_LIMIT = (64'hFFFF_FFFF_FFFF_FFFF / TABLE_N64) * TABLE_N64;
  localparam bit TABLE_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

  // Modulo support for table sizes that are not a power of two.
  localparam logic [16:0] TABLE_N17 = 17'(TABLE_ENTRIES);
  localparam logic [15:0] FOLD_K    = 16'(64'h1_0000_0000 % TABLE_N64);
  localparam logic [32:0] RECIP_M   = 33'(((64'd1 << (32 + SLOT_W)) / TABLE_N64) + 64'd1);

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [KEY_W-1:0]       key_t;

  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam slot_t  SLOT_LAST = SLOT_W'(TABLE_ENTRIES - 1);

  // Multiply by the FNV-64 prime 0x100000001b3, modulo 2^64.
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    logic [63:0] lo;
    lo = (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    return (x << 40) + lo;
  endfunction

endpackage

>>> rtl/ifpc_ram.sv
// Generic single-port synchronous RAM with registered read.
module ifpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/ipv4_flow_packet_counter_top.sv
// IPv4 flow packet counter: FNV-1a hash, linear-probe table, saturating counts.
// After reset the block sweeps the table once to clear the valid marks, one
// slot a cycle, with busy high. Each packet then hashes its eight key bytes,
// takes one rehash check plus up to 64 rehashes (rare), a fold-and-reciprocal
// modulo only when the table size is not a power of two (none at 1024
// entries), and for each probed slot a read of the table RAMs, whose read is
// registered, then a check of the slot. The result appears for one cycle under
// out_valid; the receiver cannot stall, and the next packet may be started in
// that same cycle.
module ipv4_flow_packet_counter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  output logic        out_valid,
  output logic [31:0] out_flow_count,
  output logic        out_new_flow,
  output logic        out_table_full,
  output logic [9:0]  out_slot_index
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_HASH   = 3'd2;
  localparam logic [2:0] ST_REHASH = 3'd3;
  localparam logic [2:0] ST_MOD    = 3'd4;
  localparam logic [2:0] ST_READ   = 3'd5;
  localparam logic [2:0] ST_CHECK  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  ifpc_pkg::key_t     key_r, key_nxt;
  ifpc_pkg::key_t     shf_r, shf_nxt;
  logic [63:0]        h_r, h_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  ifpc_pkg::slot_t    slot_r, slot_nxt;
  ifpc_pkg::slot_t    probe_r, probe_nxt;

  logic               ov_r, ov_nxt;
  logic [31:0]        ocnt_r, ocnt_nxt;
  logic               onew_r, onew_nxt;
  logic               ofull_r, ofull_nxt;
  logic [9:0]         oslot_r, oslot_nxt;

  logic                           key_we, cnt_we;
  logic [ifpc_pkg::KEY_W:0]       key_wdata, key_rdata;
  ifpc_pkg::count_t               cnt_wdata, cnt_rdata, cnt_inc;
  logic [64:0]                    recip_prod;
  logic                           hit;

  ifpc_ram #(.WIDTH(ifpc_pkg::KEY_W + 1), .DEPTH(ifpc_pkg::TABLE_ENTRIES)) u_key_ram (
    .clk(clk), .we(key_we), .addr(slot_r), .wdata(key_wdata), .rdata(key_rdata)
  );

  ifpc_ram #(.WIDTH(ifpc_pkg::COUNT_WIDTH), .DEPTH(ifpc_pkg::TABLE_ENTRIES)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .addr(slot_r), .wdata(cnt_wdata), .rdata(cnt_rdata)
  );

  assign busy = (state_r != ST_IDLE);
  assign hit  = (key_rdata[ifpc_pkg::KEY_W-1:0] == key_r);
  assign cnt_inc = (cnt_rdata == ifpc_pkg::COUNT_MAX) ? cnt_rdata
                                                      : cnt_rdata + 1'b1;
  assign recip_prod = 65'(h_r[31:0]) * 65'(ifpc_pkg::RECIP_M);

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    shf_nxt   = shf_r;
    h_nxt     = h_r;
    cnt_nxt   = cnt_r;
    slot_nxt  = slot_r;
    probe_nxt = probe_r;
    ov_nxt    = 1'b0;
    ocnt_nxt  = ocnt_r;
    onew_nxt  = onew_r;
    ofull_nxt = ofull_r;
    oslot_nxt = oslot_r;
    key_we    = 1'b0;
    cnt_we    = 1'b0;
    key_wdata = {1'b1, key_r};
    cnt_wdata = ifpc_pkg::COUNT_WIDTH'(1);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt   = {in_src_addr, in_dst_addr};
          shf_nxt   = {in_src_addr, in_dst_addr};
          h_nxt     = ifpc_pkg::FNV_BASIS;
          cnt_nxt   = '0;
          state_nxt = ST_HASH;
        end
      end
      ST_CLEAR: begin
        key_we    = 1'b1;
        key_wdata = '0;
        slot_nxt  = slot_r + 1'b1;
        if (slot_r == ifpc_pkg::SLOT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_HASH: begin
        h_nxt   = ifpc_pkg::fnv_mul(h_r ^ {56'd0, shf_r[63:56]});
        shf_nxt = shf_r << 8;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 7'd7) begin
          cnt_nxt   = '0;
          state_nxt = ST_REHASH;
        end
      end
      ST_REHASH: begin
        if (h_r >= ifpc_pkg::HASH_LIMIT && cnt_r < 7'(ifpc_pkg::REHASH_LIMIT)) begin
          h_nxt   = ifpc_pkg::fnv_mul(h_r) + ifpc_pkg::FNV_BASIS;
          cnt_nxt = cnt_r + 1'b1;
        end else if (ifpc_pkg::TABLE_POW2) begin
          slot_nxt  = h_r[ifpc_pkg::SLOT_W-1:0];
          probe_nxt = '0;
          state_nxt = ST_READ;
        end else begin
          slot_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        // four folds by 2^32 mod N bring the hash below 2^32, then a reciprocal divide
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r < 7'd4) begin
          h_nxt = {32'd0, h_r[31:0]} + 64'(h_r[63:32]) * 64'(ifpc_pkg::FOLD_K);
        end else if (cnt_r == 7'd4) begin
          shf_nxt = h_r;
          h_nxt   = 64'(recip_prod >> (32 + ifpc_pkg::SLOT_W));
        end else begin
          slot_nxt  = ifpc_pkg::SLOT_W'(shf_r[31:0] -
                                         h_r[31:0] * 32'(ifpc_pkg::TABLE_N17));
          probe_nxt = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!key_rdata[ifpc_pkg::KEY_W]) begin
          key_we    = 1'b1;
          cnt_we    = 1'b1;
          ov_nxt    = 1'b1;
          ocnt_nxt  = 32'd1;
          onew_nxt  = 1'b1;
          ofull_nxt = 1'b0;
          oslot_nxt = 10'(slot_r);
          state_nxt = ST_IDLE;
        end else if (hit) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_inc;
          ov_nxt    = 1'b1;
          ocnt_nxt  = 32'(cnt_inc);
          onew_nxt  = 1'b0;
          ofull_nxt = 1'b0;
          oslot_nxt = 10'(slot_r);
          state_nxt = ST_IDLE;
        end else if (probe_r == ifpc_pkg::SLOT_LAST) begin
          ov_nxt    = 1'b1;
          ocnt_nxt  = '0;
          onew_nxt  = 1'b0;
          ofull_nxt = 1'b1;
          oslot_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          slot_nxt  = (slot_r == ifpc_pkg::SLOT_LAST) ? '0 : slot_r + 1'b1;
          probe_nxt = probe_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      slot_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      ov_r    <= ov_nxt;
    end
    key_r   <= key_nxt;
    shf_r   <= shf_nxt;
    h_r     <= h_nxt;
    cnt_r   <= cnt_nxt;
    probe_r <= probe_nxt;
    ocnt_r  <= ocnt_nxt;
    onew_r  <= onew_nxt;
    ofull_r <= ofull_nxt;
    oslot_r <= oslot_nxt;
  end

  assign out_valid      = ov_r;
  assign out_flow_count = ocnt_r;
  assign out_new_flow   = onew_r;
  assign out_table_full = ofull_r;
  assign out_slot_index = oslot_r;

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_new_flow && out_table_full))
    else $error("new flow and table full together");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_flow_count == 32'd0 && out_slot_index == 10'd0))
    else $error("table full result not zeroed");

  a_new_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_new_flow) |-> out_flow_count == 32'd1)
    else $error("new flow count not one");

  a_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_CHECK)
    else $error("result without table check");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("transfer did not start work");

endmodule
